// File: hdl/assert_macros.svh
// Assertion helpers used by the scheduler core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication that must hold outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hdl/spfs_pkg.sv
`default_nettype none

package spfs_pkg;

    // Fixed field widths of the request and response channels.
    localparam int ID_W     = 16;
    localparam int PRIO_W   = 4;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_LINK,
        S_PUSH_TAIL,
        S_POP_UNLINK,
        S_POP_HEAD,
        S_POP_ID,
        S_RESULT
    } t_state;

endpackage

`default_nettype wire

// File: hdl/spfs_req_if.sv
`default_nettype none

interface spfs_req_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [spfs_pkg::ID_W-1:0]   task_id;
    logic [spfs_pkg::PRIO_W-1:0] priority_req;

    modport source (output valid, operation, task_id, priority_req, input ready);
    modport sink   (input valid, operation, task_id, priority_req, output ready);
endinterface

`default_nettype wire

// File: hdl/spfs_rsp_if.sv
`default_nettype none

interface spfs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [spfs_pkg::STATUS_W-1:0] status;
    logic [spfs_pkg::ID_W-1:0]     popped_id;
    logic [spfs_pkg::PRIO_W-1:0]   popped_priority;
    logic [spfs_pkg::COUNT_W-1:0]  task_count;
    logic                          next_valid;
    logic [spfs_pkg::ID_W-1:0]     next_id;
    logic [spfs_pkg::PRIO_W-1:0]   next_priority;

    modport source (output valid, status, popped_id, popped_priority, task_count,
                    next_valid, next_id, next_priority, input ready);
    modport sink   (input valid, status, popped_id, popped_priority, task_count,
                    next_valid, next_id, next_priority, output ready);
endinterface

`default_nettype wire

// File: hdl/strict_priority_fifo_scheduler_core.sv
// Strict-priority task scheduler with first-in-first-out order inside each level.
// Requests arrive on i_req: operation 0 pushes task_id at priority_req, 1 pops the
// oldest task of the highest non-empty level. Every request yields one response
// on o_rsp with the status, the popped task, the task count and the task that a
// following pop would return.
// Tasks sit in a slot memory ({id, link}, one read and one write port) chained per
// level; a second memory keeps each level's head and tail. The front task is also
// held in registers, so a push never has to search for it.
// The work per request depends on its kind. A push to a level that already holds
// tasks adds a read-modify-write of the old tail's link; a pop that leaves its
// level non-empty adds a read of the next task's id; a pop that empties its level
// while other levels still hold tasks adds chained reads of the new top level's
// head and then of its id. Push while full and pop while empty do no memory work.
// The response register is loaded at the end of the last cycle of the request;
// the response is valid from the next cycle, in which the next request is taken.
// Reset clears the control state at once; the memories need no clearing pass, as
// no entry's data is used before it is written. A stalled receiver keeps the
// response in the output register; the block finishes the next request, then waits.

`default_nettype none
`include "assert_macros.svh"

module strict_priority_fifo_scheduler_core #(
    parameter int PRIORITY_LEVELS = 16,
    parameter int SLOT_COUNT      = 64,
    parameter int ID_BITS         = 16
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    spfs_req_if.sink    i_req,
    spfs_rsp_if.source  o_rsp
);

    localparam int SLOT_W  = $clog2(SLOT_COUNT);
    localparam int LVL_W   = $clog2(PRIORITY_LEVELS);
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int STORE_W = (ID_BITS < spfs_pkg::ID_W) ? ID_BITS : spfs_pkg::ID_W;
    localparam int SLOT_DW = STORE_W + SLOT_W;
    localparam int LVL_DW  = 2 * SLOT_W;
    localparam logic [PRIORITY_LEVELS-1:0] LVL_ONE = PRIORITY_LEVELS'(1);

    spfs_pkg::t_state r_state, n_state;

    logic [PRIORITY_LEVELS-1:0] r_nonempty, n_nonempty;
    logic [SLOT_W-1:0]          r_free_head, n_free_head;
    logic                       r_free_valid, n_free_valid;
    logic [CNT_W-1:0]           r_fresh, n_fresh;
    logic [CNT_W-1:0]           r_total, n_total;

    logic [SLOT_W-1:0]  r_front_slot, n_front_slot;
    logic [STORE_W-1:0] r_front_id, n_front_id;
    logic [LVL_W-1:0]   r_front_lvl, n_front_lvl;

    logic [STORE_W-1:0] r_cur_id, n_cur_id;
    logic [LVL_W-1:0]   r_cur_lvl, n_cur_lvl;
    logic [SLOT_W-1:0]  r_new_slot, n_new_slot;
    logic [SLOT_W-1:0]  r_tail, n_tail;

    logic [spfs_pkg::STATUS_W-1:0] r_status, n_status;
    logic [STORE_W-1:0]            r_pop_id, n_pop_id;
    logic [LVL_W-1:0]              r_pop_lvl, n_pop_lvl;

    logic                           r_out_valid, n_out_valid;
    logic [spfs_pkg::STATUS_W-1:0]  r_out_status, n_out_status;
    logic [spfs_pkg::ID_W-1:0]      r_out_pop_id, n_out_pop_id;
    logic [spfs_pkg::PRIO_W-1:0]    r_out_pop_prio, n_out_pop_prio;
    logic [spfs_pkg::COUNT_W-1:0]   r_out_count, n_out_count;
    logic                           r_out_next_valid, n_out_next_valid;
    logic [spfs_pkg::ID_W-1:0]      r_out_next_id, n_out_next_id;
    logic [spfs_pkg::PRIO_W-1:0]    r_out_next_prio, n_out_next_prio;

    logic               w_slot_we, w_slot_re;
    logic [SLOT_W-1:0]  w_slot_waddr, w_slot_raddr;
    logic [SLOT_DW-1:0] w_slot_wdata, w_slot_rdata;
    logic               w_lvl_we, w_lvl_re;
    logic [LVL_W-1:0]   w_lvl_waddr, w_lvl_raddr;
    logic [LVL_DW-1:0]  w_lvl_wdata, w_lvl_rdata;

    logic [STORE_W-1:0]         w_slot_rd_id;
    logic [SLOT_W-1:0]          w_slot_rd_link;
    logic [SLOT_W-1:0]          w_lvl_rd_head;
    logic [SLOT_W-1:0]          w_lvl_rd_tail;
    logic [LVL_W-1:0]           w_req_lvl;
    logic                       w_full;
    logic                       w_any;
    logic                       w_rsp_free;
    logic                       w_cur_ne;
    logic [SLOT_W-1:0]          w_take_slot;
    logic                       w_pop_last;
    logic [PRIORITY_LEVELS-1:0] w_left;
    logic [LVL_W-1:0]           w_left_top;
    logic [31:0]                w_pop_lvl32;
    logic [31:0]                w_front_lvl32;
    logic [31:0]                w_total32;

    spfs_ram #(
        .WIDTH (SLOT_DW),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_slot_we),
        .i_wr_addr (w_slot_waddr),
        .i_wr_data (w_slot_wdata),
        .i_rd_en   (w_slot_re),
        .i_rd_addr (w_slot_raddr),
        .o_rd_data (w_slot_rdata)
    );

    spfs_ram #(
        .WIDTH (LVL_DW),
        .DEPTH (PRIORITY_LEVELS)
    ) u_level_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_lvl_we),
        .i_wr_addr (w_lvl_waddr),
        .i_wr_data (w_lvl_wdata),
        .i_rd_en   (w_lvl_re),
        .i_rd_addr (w_lvl_raddr),
        .o_rd_data (w_lvl_rdata)
    );

    spfs_level_find #(
        .LEVELS (PRIORITY_LEVELS)
    ) u_level_find (
        .i_levels (w_left),
        .o_top    (w_left_top)
    );

    assign w_slot_rd_id   = w_slot_rdata[SLOT_DW-1:SLOT_W];
    assign w_slot_rd_link = w_slot_rdata[SLOT_W-1:0];
    assign w_lvl_rd_head  = w_lvl_rdata[LVL_DW-1:SLOT_W];
    assign w_lvl_rd_tail  = w_lvl_rdata[SLOT_W-1:0];

    // Out-of-range levels saturate to the top level.
    assign w_req_lvl = (32'(i_req.priority_req) >= PRIORITY_LEVELS) ?
                       LVL_W'(PRIORITY_LEVELS - 1) : LVL_W'(i_req.priority_req);

    assign w_full      = (r_total == CNT_W'(SLOT_COUNT));
    assign w_any       = |r_nonempty;
    assign w_rsp_free  = !r_out_valid || o_rsp.ready;
    assign w_cur_ne    = |(r_nonempty & (LVL_ONE << r_cur_lvl));
    assign w_take_slot = r_free_valid ? r_free_head : r_fresh[SLOT_W-1:0];
    assign w_pop_last  = (r_front_slot == w_lvl_rd_tail);
    assign w_left      = r_nonempty & ~(LVL_ONE << r_front_lvl);

    assign w_pop_lvl32   = 32'(r_pop_lvl);
    assign w_front_lvl32 = 32'(r_front_lvl);
    assign w_total32     = 32'(r_total);

    always_comb begin
        n_state = r_state;
        case (r_state)
            spfs_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.operation == spfs_pkg::OP_POP) begin
                        n_state = w_any ? spfs_pkg::S_POP_UNLINK : spfs_pkg::S_RESULT;
                    end else begin
                        n_state = w_full ? spfs_pkg::S_RESULT : spfs_pkg::S_PUSH_LINK;
                    end
                end
            end
            spfs_pkg::S_PUSH_LINK: begin
                n_state = w_cur_ne ? spfs_pkg::S_PUSH_TAIL : spfs_pkg::S_RESULT;
            end
            spfs_pkg::S_PUSH_TAIL: begin
                n_state = spfs_pkg::S_RESULT;
            end
            spfs_pkg::S_POP_UNLINK: begin
                if (w_pop_last) begin
                    n_state = (w_left == '0) ? spfs_pkg::S_RESULT : spfs_pkg::S_POP_HEAD;
                end else begin
                    n_state = spfs_pkg::S_POP_ID;
                end
            end
            spfs_pkg::S_POP_HEAD: begin
                n_state = spfs_pkg::S_POP_ID;
            end
            spfs_pkg::S_POP_ID: begin
                n_state = spfs_pkg::S_RESULT;
            end
            spfs_pkg::S_RESULT: begin
                if (w_rsp_free) begin
                    n_state = spfs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spfs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_nonempty   = r_nonempty;
        n_free_head  = r_free_head;
        n_free_valid = r_free_valid;
        n_fresh      = r_fresh;
        n_total      = r_total;
        n_front_slot = r_front_slot;
        n_front_id   = r_front_id;
        n_front_lvl  = r_front_lvl;
        n_cur_id     = r_cur_id;
        n_cur_lvl    = r_cur_lvl;
        n_new_slot   = r_new_slot;
        n_tail       = r_tail;
        n_status     = r_status;
        n_pop_id     = r_pop_id;
        n_pop_lvl    = r_pop_lvl;

        n_out_valid      = r_out_valid && !o_rsp.ready;
        n_out_status     = r_out_status;
        n_out_pop_id     = r_out_pop_id;
        n_out_pop_prio   = r_out_pop_prio;
        n_out_count      = r_out_count;
        n_out_next_valid = r_out_next_valid;
        n_out_next_id    = r_out_next_id;
        n_out_next_prio  = r_out_next_prio;

        w_slot_we    = 1'b0;
        w_slot_waddr = '0;
        w_slot_wdata = '0;
        w_slot_re    = 1'b0;
        w_slot_raddr = '0;
        w_lvl_we     = 1'b0;
        w_lvl_waddr  = '0;
        w_lvl_wdata  = '0;
        w_lvl_re     = 1'b0;
        w_lvl_raddr  = '0;

        case (r_state)
            spfs_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_cur_id  = i_req.task_id[STORE_W-1:0];
                    n_cur_lvl = w_req_lvl;
                    n_pop_id  = '0;
                    n_pop_lvl = '0;
                    if (i_req.operation == spfs_pkg::OP_POP) begin
                        if (w_any) begin
                            n_status     = spfs_pkg::ST_OK;
                            n_pop_id     = r_front_id;
                            n_pop_lvl    = r_front_lvl;
                            w_slot_re    = 1'b1;
                            w_slot_raddr = r_front_slot;
                            w_lvl_re     = 1'b1;
                            w_lvl_raddr  = r_front_lvl;
                        end else begin
                            n_status = spfs_pkg::ST_EMPTY;
                        end
                    end else begin
                        if (w_full) begin
                            n_status = spfs_pkg::ST_FULL;
                        end else begin
                            n_status     = spfs_pkg::ST_OK;
                            w_slot_re    = 1'b1;
                            w_slot_raddr = r_free_head;
                            w_lvl_re     = 1'b1;
                            w_lvl_raddr  = w_req_lvl;
                        end
                    end
                end
            end
            spfs_pkg::S_PUSH_LINK: begin
                // The slot comes from the free list when it has entries, else fresh.
                if (r_free_valid) begin
                    n_free_head  = w_slot_rd_link;
                    n_free_valid = (r_fresh > (r_total + CNT_W'(1)));
                end else begin
                    n_fresh = r_fresh + CNT_W'(1);
                end
                w_slot_we    = 1'b1;
                w_slot_waddr = w_take_slot;
                w_slot_wdata = {r_cur_id, SLOT_W'(0)};
                w_lvl_we     = 1'b1;
                w_lvl_waddr  = r_cur_lvl;
                w_lvl_wdata  = {(w_cur_ne ? w_lvl_rd_head : w_take_slot), w_take_slot};
                n_nonempty   = r_nonempty | (LVL_ONE << r_cur_lvl);
                n_total      = r_total + CNT_W'(1);
                if (!w_any || (r_cur_lvl > r_front_lvl)) begin
                    n_front_slot = w_take_slot;
                    n_front_id   = r_cur_id;
                    n_front_lvl  = r_cur_lvl;
                end
                if (w_cur_ne) begin
                    // The old tail's id is read back so its link can be rewritten.
                    w_slot_re    = 1'b1;
                    w_slot_raddr = w_lvl_rd_tail;
                    n_tail       = w_lvl_rd_tail;
                    n_new_slot   = w_take_slot;
                end
            end
            spfs_pkg::S_PUSH_TAIL: begin
                w_slot_we    = 1'b1;
                w_slot_waddr = r_tail;
                w_slot_wdata = {w_slot_rd_id, r_new_slot};
            end
            spfs_pkg::S_POP_UNLINK: begin
                w_slot_we    = 1'b1;
                w_slot_waddr = r_front_slot;
                w_slot_wdata = {r_front_id, (r_free_valid ? r_free_head : SLOT_W'(0))};
                n_free_head  = r_front_slot;
                n_free_valid = 1'b1;
                n_total      = r_total - CNT_W'(1);
                if (w_pop_last) begin
                    n_nonempty = w_left;
                    if (w_left != '0) begin
                        w_lvl_re    = 1'b1;
                        w_lvl_raddr = w_left_top;
                        n_front_lvl = w_left_top;
                    end
                end else begin
                    w_lvl_we     = 1'b1;
                    w_lvl_waddr  = r_front_lvl;
                    w_lvl_wdata  = {w_slot_rd_link, w_lvl_rd_tail};
                    n_front_slot = w_slot_rd_link;
                    w_slot_re    = 1'b1;
                    w_slot_raddr = w_slot_rd_link;
                end
            end
            spfs_pkg::S_POP_HEAD: begin
                n_front_slot = w_lvl_rd_head;
                w_slot_re    = 1'b1;
                w_slot_raddr = w_lvl_rd_head;
            end
            spfs_pkg::S_POP_ID: begin
                n_front_id = w_slot_rd_id;
            end
            spfs_pkg::S_RESULT: begin
                if (w_rsp_free) begin
                    n_out_valid      = 1'b1;
                    n_out_status     = r_status;
                    n_out_pop_id     = spfs_pkg::ID_W'(r_pop_id);
                    n_out_pop_prio   = w_pop_lvl32[spfs_pkg::PRIO_W-1:0];
                    n_out_count      = w_total32[spfs_pkg::COUNT_W-1:0];
                    n_out_next_valid = w_any;
                    n_out_next_id    = w_any ? spfs_pkg::ID_W'(r_front_id) : '0;
                    n_out_next_prio  = w_any ? w_front_lvl32[spfs_pkg::PRIO_W-1:0] : '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= spfs_pkg::S_IDLE;
            r_nonempty   <= '0;
            r_free_head  <= '0;
            r_free_valid <= 1'b0;
            r_fresh      <= '0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_nonempty   <= n_nonempty;
            r_free_head  <= n_free_head;
            r_free_valid <= n_free_valid;
            r_fresh      <= n_fresh;
            r_total      <= n_total;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front_slot     <= n_front_slot;
        r_front_id       <= n_front_id;
        r_front_lvl      <= n_front_lvl;
        r_cur_id         <= n_cur_id;
        r_cur_lvl        <= n_cur_lvl;
        r_new_slot       <= n_new_slot;
        r_tail           <= n_tail;
        r_status         <= n_status;
        r_pop_id         <= n_pop_id;
        r_pop_lvl        <= n_pop_lvl;
        r_out_status     <= n_out_status;
        r_out_pop_id     <= n_out_pop_id;
        r_out_pop_prio   <= n_out_pop_prio;
        r_out_count      <= n_out_count;
        r_out_next_valid <= n_out_next_valid;
        r_out_next_id    <= n_out_next_id;
        r_out_next_prio  <= n_out_next_prio;
    end

    assign i_req.ready           = (r_state == spfs_pkg::S_IDLE);
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.popped_id       = r_out_pop_id;
    assign o_rsp.popped_priority = r_out_pop_prio;
    assign o_rsp.task_count      = r_out_count;
    assign o_rsp.next_valid      = r_out_next_valid;
    assign o_rsp.next_id         = r_out_next_id;
    assign o_rsp.next_priority   = r_out_next_prio;

    `ASSERT_CLK(a_total_bound, i_clk, i_rst_n,
                r_total <= CNT_W'(SLOT_COUNT), "task count above capacity")
    `ASSERT_IMPLY(a_count_levels, i_clk, i_rst_n, r_state == spfs_pkg::S_IDLE,
                  (r_total == '0) == (r_nonempty == '0), "task count disagrees with level flags")
    `ASSERT_IMPLY(a_free_list, i_clk, i_rst_n, r_state == spfs_pkg::S_IDLE,
                  r_free_valid == (r_fresh > r_total), "free list flag disagrees with slot counts")
    `ASSERT_IMPLY(a_push_not_full, i_clk, i_rst_n, r_state == spfs_pkg::S_PUSH_LINK,
                  r_total != CNT_W'(SLOT_COUNT), "push proceeded while full")

endmodule

`default_nettype wire

// File: hdl/spfs_ram.sv
`default_nettype none

module spfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: hdl/spfs_level_find.sv
`default_nettype none

module spfs_level_find #(
    parameter int LEVELS = 16
) (
    input  wire logic [LEVELS-1:0]         i_levels,
    output logic      [$clog2(LEVELS)-1:0] o_top
);

    localparam int LW = $clog2(LEVELS);

    // Highest set bit wins; the result is zero when no bit is set.
    always_comb begin
        o_top = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (i_levels[i]) begin
                o_top = LW'(i);
            end
        end
    end

endmodule

`default_nettype wire
